FILE: hw/rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared codes, widths and bundles for the pipelined fetch stage.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned CODE_W = 4;

  // Instruction codes
  localparam logic [CODE_W-1:0] IC_HALT   = 4'h0;
  localparam logic [CODE_W-1:0] IC_NOP    = 4'h1;
  localparam logic [CODE_W-1:0] IC_RRMOVQ = 4'h2;
  localparam logic [CODE_W-1:0] IC_IRMOVQ = 4'h3;
  localparam logic [CODE_W-1:0] IC_RMMOVQ = 4'h4;
  localparam logic [CODE_W-1:0] IC_MRMOVQ = 4'h5;
  localparam logic [CODE_W-1:0] IC_OPQ    = 4'h6;
  localparam logic [CODE_W-1:0] IC_JXX    = 4'h7;
  localparam logic [CODE_W-1:0] IC_CALL   = 4'h8;
  localparam logic [CODE_W-1:0] IC_RET    = 4'h9;
  localparam logic [CODE_W-1:0] IC_PUSHQ  = 4'hA;
  localparam logic [CODE_W-1:0] IC_POPQ   = 4'hB;

  localparam logic [CODE_W-1:0] FN_NONE = 4'h0;
  localparam logic [CODE_W-1:0] NO_REG  = 4'hF;

  // Status codes
  localparam logic [1:0] ST_AOK = 2'd0;
  localparam logic [1:0] ST_HLT = 2'd1;
  localparam logic [1:0] ST_ADR = 2'd2;
  localparam logic [1:0] ST_INS = 2'd3;

  // Address increments by instruction length
  localparam logic [3:0] INC_REG_CONST = 4'd10;
  localparam logic [3:0] INC_CONST     = 4'd9;
  localparam logic [3:0] INC_REG       = 4'd2;
  localparam logic [3:0] INC_BYTE      = 4'd1;

  typedef struct packed {
    logic fetch_stall;
    logic decode_stall;
    logic decode_bubble;
  } hazard_t;

  typedef struct packed {
    logic use_fallthrough;
    logic use_return;
  } pc_sel_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CODE_W-1:0] icode;
    logic [CODE_W-1:0] ifun;
    logic [CODE_W-1:0] reg_a;
    logic [CODE_W-1:0] reg_b;
    logic [ADDR_W-1:0] val_c;
    logic [ADDR_W-1:0] val_p;
    logic [ADDR_W-1:0] pred_pc;
  } dec_t;

endpackage

FILE: hw/rtl/pfs_decode.sv
// ----------------------------------------------------------------------------
// pfs_decode
// Split the fetched bytes into fields, size the instruction and predict.
// ----------------------------------------------------------------------------
module pfs_decode (
  input  logic [pfs_pkg::ADDR_W-1:0] pc,
  input  logic                       fetch_error,
  input  logic [7:0]                 instr_byte,
  input  logic [7:0]                 reg_byte,
  input  logic [pfs_pkg::ADDR_W-1:0] const_word,
  output pfs_pkg::dec_t              dec
);

  logic [pfs_pkg::CODE_W-1:0] ic;
  logic [pfs_pkg::CODE_W-1:0] fn;
  logic                       need_regs;
  logic                       need_const;
  logic                       is_valid;
  logic [3:0]                 inc;

  // Force a nop on a failed fetch
  assign ic = fetch_error ? pfs_pkg::IC_NOP : instr_byte[7:4];
  assign fn = fetch_error ? pfs_pkg::FN_NONE : instr_byte[3:0];

  always_comb begin
    need_regs  = 1'b0;
    need_const = 1'b0;
    is_valid   = 1'b1;
    unique case (ic)
      pfs_pkg::IC_HALT, pfs_pkg::IC_NOP, pfs_pkg::IC_RET: begin
      end
      pfs_pkg::IC_RRMOVQ, pfs_pkg::IC_OPQ,
      pfs_pkg::IC_PUSHQ, pfs_pkg::IC_POPQ: begin
        need_regs = 1'b1;
      end
      pfs_pkg::IC_IRMOVQ, pfs_pkg::IC_RMMOVQ, pfs_pkg::IC_MRMOVQ: begin
        need_regs  = 1'b1;
        need_const = 1'b1;
      end
      pfs_pkg::IC_JXX, pfs_pkg::IC_CALL: begin
        need_const = 1'b1;
      end
      default: begin
        is_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case ({need_regs, need_const})
      2'b11:   inc = pfs_pkg::INC_REG_CONST;
      2'b10:   inc = pfs_pkg::INC_REG;
      2'b01:   inc = pfs_pkg::INC_CONST;
      default: inc = pfs_pkg::INC_BYTE;
    endcase
  end

  always_comb begin
    dec.icode = ic;
    dec.ifun  = fn;
    dec.reg_a = need_regs ? reg_byte[7:4] : pfs_pkg::NO_REG;
    dec.reg_b = need_regs ? reg_byte[3:0] : pfs_pkg::NO_REG;
    dec.val_c = need_const ? const_word : '0;
    dec.val_p = pc + {{(pfs_pkg::ADDR_W-4){1'b0}}, inc};
    priority if (fetch_error) begin
      dec.status = pfs_pkg::ST_ADR;
    end else if (!is_valid) begin
      dec.status = pfs_pkg::ST_INS;
    end else if (ic == pfs_pkg::IC_HALT) begin
      dec.status = pfs_pkg::ST_HLT;
    end else begin
      dec.status = pfs_pkg::ST_AOK;
    end
    dec.pred_pc = (ic == pfs_pkg::IC_JXX || ic == pfs_pkg::IC_CALL) ? dec.val_c : dec.val_p;
  end

endmodule

FILE: hw/rtl/pfs_ctrl.sv
// ----------------------------------------------------------------------------
// pfs_ctrl
// Hazard control for the F and D registers and fetch address choice.
// ----------------------------------------------------------------------------
module pfs_ctrl (
  input  logic [15:0]                stage_icodes,
  input  logic [1:0]                 cond_flags,
  input  logic [pfs_pkg::CODE_W-1:0] load_dst_reg,
  input  logic [pfs_pkg::CODE_W-1:0] src_reg_a,
  input  logic [pfs_pkg::CODE_W-1:0] src_reg_b,
  output pfs_pkg::hazard_t           hz,
  output pfs_pkg::pc_sel_t           sel
);

  logic [pfs_pkg::CODE_W-1:0] d_ic;
  logic [pfs_pkg::CODE_W-1:0] e_ic;
  logic [pfs_pkg::CODE_W-1:0] m_ic;
  logic [pfs_pkg::CODE_W-1:0] w_ic;
  logic                       load_use;
  logic                       ret_fly;

  assign d_ic = stage_icodes[15:12];
  assign e_ic = stage_icodes[11:8];
  assign m_ic = stage_icodes[7:4];
  assign w_ic = stage_icodes[3:0];

  assign load_use = (e_ic == pfs_pkg::IC_MRMOVQ || e_ic == pfs_pkg::IC_POPQ) &&
                    (load_dst_reg == src_reg_a || load_dst_reg == src_reg_b);
  assign ret_fly  = d_ic == pfs_pkg::IC_RET || e_ic == pfs_pkg::IC_RET ||
                    m_ic == pfs_pkg::IC_RET;

  always_comb begin
    hz.fetch_stall   = load_use || ret_fly;
    hz.decode_stall  = load_use;
    hz.decode_bubble = (e_ic == pfs_pkg::IC_JXX && !cond_flags[0]) || (!load_use && ret_fly);
    sel.use_fallthrough = m_ic == pfs_pkg::IC_JXX && !cond_flags[1];
    sel.use_return      = w_ic == pfs_pkg::IC_RET;
  end

endmodule

FILE: hw/rtl/pipelined_fetch_stage_core.sv
// ----------------------------------------------------------------------------
// pipelined_fetch_stage_core
// Fetch address select, instruction split and hazard control of the fetch
// stage, with an input register and a result register around the logic.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register, which drives the result
//   ports. Throughput: one transaction per cycle while out_stall is low;
//   the PC state is updated as each transaction leaves the input register,
//   in time for the one behind it.
// Reset: clears both valid flags, the predicted PC and the selected PC.
// ----------------------------------------------------------------------------
module pipelined_fetch_stage_core (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] stage_icodes,
  input  logic [1:0]  cond_flags,
  input  logic [63:0] branch_fallthrough,
  input  logic [63:0] return_addr,
  input  logic        fetch_error,
  input  logic [7:0]  instr_byte,
  input  logic [7:0]  reg_byte,
  input  logic [63:0] const_word,
  input  logic [3:0]  load_dst_reg,
  input  logic [3:0]  src_reg_a,
  input  logic [3:0]  src_reg_b,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] fetch_pc,
  output logic [1:0]  status,
  output logic [3:0]  icode_out,
  output logic [3:0]  ifun_out,
  output logic [3:0]  reg_a,
  output logic [3:0]  reg_b,
  output logic [63:0] val_c,
  output logic [63:0] val_p,
  output logic        fetch_stall,
  output logic        decode_stall,
  output logic        decode_bubble
);

  // Input register
  logic        s1_valid;
  logic        s1_cmd;
  logic [15:0] s1_icodes;
  logic [1:0]  s1_flags;
  logic [63:0] s1_fallthrough;
  logic [63:0] s1_return;
  logic        s1_error;
  logic [7:0]  s1_instr;
  logic [7:0]  s1_regb;
  logic [63:0] s1_const;
  logic [3:0]  s1_dstm;
  logic [3:0]  s1_srca;
  logic [3:0]  s1_srcb;

  // Architectural PC state
  logic [63:0] predicted_pc;
  logic [63:0] selected_pc;

  logic              s1_adv;
  logic              s1_fire;
  logic              in_take;
  logic [63:0]       sel_pc;
  pfs_pkg::hazard_t  hz;
  pfs_pkg::pc_sel_t  sel;
  pfs_pkg::dec_t     dec;

  // Advance the input register whenever the result register is empty or
  // being drained this cycle; stall the source only while a transaction
  // is stuck in the input register.
  assign s1_adv   = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  pfs_ctrl u_ctrl (
    .stage_icodes (s1_icodes),
    .cond_flags   (s1_flags),
    .load_dst_reg (s1_dstm),
    .src_reg_a    (s1_srca),
    .src_reg_b    (s1_srcb),
    .hz           (hz),
    .sel          (sel)
  );

  // Decode always works from the address latched by the last select
  pfs_decode u_decode (
    .pc          (selected_pc),
    .fetch_error (s1_error),
    .instr_byte  (s1_instr),
    .reg_byte    (s1_regb),
    .const_word  (s1_const),
    .dec         (dec)
  );

  // Mispredicted branch wins over a returning ret, then the prediction
  always_comb begin
    priority if (sel.use_fallthrough) begin
      sel_pc = s1_fallthrough;
    end else if (sel.use_return) begin
      sel_pc = s1_return;
    end else begin
      sel_pc = predicted_pc;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd         <= cmd;
      s1_icodes      <= stage_icodes;
      s1_flags       <= cond_flags;
      s1_fallthrough <= branch_fallthrough;
      s1_return      <= return_addr;
      s1_error       <= fetch_error;
      s1_instr       <= instr_byte;
      s1_regb        <= reg_byte;
      s1_const       <= const_word;
      s1_dstm        <= load_dst_reg;
      s1_srca        <= src_reg_a;
      s1_srcb        <= src_reg_b;
    end
  end

  // As the transaction leaves the input register, a select updates the selected
  // PC and an unstalled fetch the prediction; the next transaction sees it on the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      predicted_pc <= '0;
      selected_pc  <= '0;
    end else if (s1_fire) begin
      if (!s1_cmd) begin
        selected_pc <= sel_pc;
      end else if (!hz.fetch_stall) begin
        predicted_pc <= dec.pred_pc;
      end
    end
  end

  // Result register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (!s1_cmd) begin
        // A select reports only the chosen address
        fetch_pc      <= sel_pc;
        status        <= pfs_pkg::ST_AOK;
        icode_out     <= '0;
        ifun_out      <= '0;
        reg_a         <= '0;
        reg_b         <= '0;
        val_c         <= '0;
        val_p         <= '0;
        fetch_stall   <= 1'b0;
        decode_stall  <= 1'b0;
        decode_bubble <= 1'b0;
      end else begin
        fetch_pc      <= selected_pc;
        status        <= dec.status;
        icode_out     <= dec.icode;
        ifun_out      <= dec.ifun;
        reg_a         <= dec.reg_a;
        reg_b         <= dec.reg_b;
        val_c         <= dec.val_c;
        val_p         <= dec.val_p;
        fetch_stall   <= hz.fetch_stall;
        decode_stall  <= hz.decode_stall;
        decode_bubble <= hz.decode_bubble;
      end
    end
  end

  // A load-use stall always stalls fetch as well
  a_dstall_fstall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!decode_stall || fetch_stall))
    else $error("decode stall without fetch stall");

  // Stall and bubble on D never coincide
  a_stall_bubble: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(decode_stall && decode_bubble))
    else $error("decode stall and bubble together");

  // A stalled fetch keeps the prediction
  a_pred_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_cmd && hz.fetch_stall) |=> predicted_pc == $past(predicted_pc))
    else $error("prediction changed under fetch stall");

  // A select result reports the address that was latched
  a_select_pc: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_cmd) |=> (out_valid && selected_pc == fetch_pc))
    else $error("selected address mismatch");

  // The source is only held back by an occupied input register
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stall with nothing held");

endmodule

FILE: sim/fetch_stage_checker.sv
// ----------------------------------------------------------------------------
// fetch_stage_checker
// Watches both channels of the fetch stage. It predicts the result of every
// accepted input transaction and compares each accepted result, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module fetch_stage_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] stage_icodes,
  input  logic [1:0]  cond_flags,
  input  logic [63:0] branch_fallthrough,
  input  logic [63:0] return_addr,
  input  logic        fetch_error,
  input  logic [7:0]  instr_byte,
  input  logic [7:0]  reg_byte,
  input  logic [63:0] const_word,
  input  logic [3:0]  load_dst_reg,
  input  logic [3:0]  src_reg_a,
  input  logic [3:0]  src_reg_b,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] fetch_pc,
  input  logic [1:0]  status,
  input  logic [3:0]  icode_out,
  input  logic [3:0]  ifun_out,
  input  logic [3:0]  reg_a,
  input  logic [3:0]  reg_b,
  input  logic [63:0] val_c,
  input  logic [63:0] val_p,
  input  logic        fetch_stall,
  input  logic        decode_stall,
  input  logic        decode_bubble,
  output int          fail_count,
  output int          outstanding,
  output int          select_count,
  output int          fetch_count
);

  typedef struct {
    logic [63:0] fetch_pc;
    logic [1:0]  status;
    logic [3:0]  icode;
    logic [3:0]  ifun;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [63:0] val_c;
    logic [63:0] val_p;
    logic        fetch_stall;
    logic        decode_stall;
    logic        decode_bubble;
  } fetch_result_t;

  fetch_result_t pending_results[$];
  logic [63:0]   predicted_pc_q;
  logic [63:0]   selected_pc_q;
  int            mismatches = 0;
  int            n_select = 0;
  int            n_fetch = 0;

  // Compute the result of the transaction on the input ports and update the
  // predicted and selected addresses.
  task automatic predict_fetch_and_hazards();
    fetch_result_t r;
    logic [3:0]    d_ic, e_ic, m_ic, w_ic, ic, fn;
    logic          need_regs, need_const, load_use, ret_in_flight;
    logic [63:0]   next_pc;
    d_ic = stage_icodes[15:12];
    e_ic = stage_icodes[11:8];
    m_ic = stage_icodes[7:4];
    w_ic = stage_icodes[3:0];
    r = '{fetch_pc: '0, status: pfs_pkg::ST_AOK, icode: '0, ifun: '0, reg_a: '0,
          reg_b: '0, val_c: '0, val_p: '0, fetch_stall: 1'b0, decode_stall: 1'b0,
          decode_bubble: 1'b0};
    if (cmd == 1'b0) begin
      if (m_ic == pfs_pkg::IC_JXX && !cond_flags[1])
        selected_pc_q = branch_fallthrough;
      else if (w_ic == pfs_pkg::IC_RET)
        selected_pc_q = return_addr;
      else
        selected_pc_q = predicted_pc_q;
      r.fetch_pc = selected_pc_q;
      n_select++;
    end else begin
      ic = instr_byte[7:4];
      fn = instr_byte[3:0];
      if (fetch_error) begin
        ic = pfs_pkg::IC_NOP;
        fn = pfs_pkg::FN_NONE;
      end
      need_regs  = ic inside {pfs_pkg::IC_RRMOVQ, pfs_pkg::IC_IRMOVQ, pfs_pkg::IC_RMMOVQ,
                              pfs_pkg::IC_MRMOVQ, pfs_pkg::IC_OPQ, pfs_pkg::IC_PUSHQ,
                              pfs_pkg::IC_POPQ};
      need_const = ic inside {pfs_pkg::IC_IRMOVQ, pfs_pkg::IC_RMMOVQ, pfs_pkg::IC_MRMOVQ,
                              pfs_pkg::IC_JXX, pfs_pkg::IC_CALL};
      r.fetch_pc = selected_pc_q;
      r.icode    = ic;
      r.ifun     = fn;
      r.reg_a    = need_regs ? reg_byte[7:4] : pfs_pkg::NO_REG;
      r.reg_b    = need_regs ? reg_byte[3:0] : pfs_pkg::NO_REG;
      r.val_c    = need_const ? const_word : 64'd0;
      if (need_regs && need_const)
        r.val_p = selected_pc_q + 64'(pfs_pkg::INC_REG_CONST);
      else if (need_regs)
        r.val_p = selected_pc_q + 64'(pfs_pkg::INC_REG);
      else if (need_const)
        r.val_p = selected_pc_q + 64'(pfs_pkg::INC_CONST);
      else
        r.val_p = selected_pc_q + 64'(pfs_pkg::INC_BYTE);
      if (fetch_error)
        r.status = pfs_pkg::ST_ADR;
      else if (ic > pfs_pkg::IC_POPQ)
        r.status = pfs_pkg::ST_INS;
      else if (ic == pfs_pkg::IC_HALT)
        r.status = pfs_pkg::ST_HLT;
      else
        r.status = pfs_pkg::ST_AOK;
      next_pc = (ic == pfs_pkg::IC_JXX || ic == pfs_pkg::IC_CALL) ? r.val_c : r.val_p;

      load_use = (e_ic == pfs_pkg::IC_MRMOVQ || e_ic == pfs_pkg::IC_POPQ) &&
                 (load_dst_reg == src_reg_a || load_dst_reg == src_reg_b);
      ret_in_flight = (d_ic == pfs_pkg::IC_RET) || (e_ic == pfs_pkg::IC_RET) ||
                      (m_ic == pfs_pkg::IC_RET);
      r.fetch_stall   = load_use || ret_in_flight;
      r.decode_stall  = load_use;
      r.decode_bubble = (e_ic == pfs_pkg::IC_JXX && !cond_flags[0]) ||
                        (!load_use && ret_in_flight);
      // Hold the prediction while fetch stalls.
      if (!r.fetch_stall)
        predicted_pc_q = next_pc;
      n_fetch++;
    end
    pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic compare_result();
    fetch_result_t want;
    if (pending_results.size() == 0) begin
      $error("result transaction with no prediction pending, fetch_pc %h", fetch_pc);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      check_field("fetch_pc", want.fetch_pc, fetch_pc);
      check_field("status", 64'(want.status), 64'(status));
      check_field("icode_out", 64'(want.icode), 64'(icode_out));
      check_field("ifun_out", 64'(want.ifun), 64'(ifun_out));
      check_field("reg_a", 64'(want.reg_a), 64'(reg_a));
      check_field("reg_b", 64'(want.reg_b), 64'(reg_b));
      check_field("val_c", want.val_c, val_c);
      check_field("val_p", want.val_p, val_p);
      check_field("fetch_stall", 64'(want.fetch_stall), 64'(fetch_stall));
      check_field("decode_stall", 64'(want.decode_stall), 64'(decode_stall));
      check_field("decode_bubble", 64'(want.decode_bubble), 64'(decode_bubble));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      predicted_pc_q = '0;
      selected_pc_q  = '0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall)
        compare_result();
      if (in_valid && !in_stall)
        predict_fetch_and_hazards();
    end
    outstanding  <= pending_results.size();
    fail_count   <= mismatches;
    select_count <= n_select;
    fetch_count  <= n_fetch;
  end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the pipelined fetch stage. A short directed run
// hits reset state, address selection priority, every icode, each hazard and
// address wrap; random select/fetch pairs with noise follow under three
// handshake idling profiles. Checking lives in fetch_stage_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 510;

  typedef struct {
    logic        cmd;
    logic [15:0] stage_icodes;
    logic [1:0]  cond_flags;
    logic [63:0] branch_fallthrough;
    logic [63:0] return_addr;
    logic        fetch_error;
    logic [7:0]  instr_byte;
    logic [7:0]  reg_byte;
    logic [63:0] const_word;
    logic [3:0]  load_dst_reg;
    logic [3:0]  src_reg_a;
    logic [3:0]  src_reg_b;
  } fetch_txn_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [15:0] stage_icodes;
  logic [1:0]  cond_flags;
  logic [63:0] branch_fallthrough;
  logic [63:0] return_addr;
  logic        fetch_error;
  logic [7:0]  instr_byte;
  logic [7:0]  reg_byte;
  logic [63:0] const_word;
  logic [3:0]  load_dst_reg;
  logic [3:0]  src_reg_a;
  logic [3:0]  src_reg_b;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] fetch_pc;
  logic [1:0]  status;
  logic [3:0]  icode_out;
  logic [3:0]  ifun_out;
  logic [3:0]  reg_a;
  logic [3:0]  reg_b;
  logic [63:0] val_c;
  logic [63:0] val_p;
  logic        fetch_stall;
  logic        decode_stall;
  logic        decode_bubble;

  int fail_count;
  int outstanding;
  int select_count;
  int fetch_count;

  // Idle percentages of the sender and of the receiver for the current phase.
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  pipelined_fetch_stage_core DUT (.*);

  fetch_stage_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result channel at random; rate follows the current phase.
  always @(posedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
  end

  // End the run when no transaction moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // Present one transaction and hold it until accepted. Insert random idle
  // cycles ahead of it according to the sender's idle rate.
  task automatic send(input fetch_txn_t t);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    cmd                <= t.cmd;
    stage_icodes       <= t.stage_icodes;
    cond_flags         <= t.cond_flags;
    branch_fallthrough <= t.branch_fallthrough;
    return_addr        <= t.return_addr;
    fetch_error        <= t.fetch_error;
    instr_byte         <= t.instr_byte;
    reg_byte           <= t.reg_byte;
    const_word         <= t.const_word;
    load_dst_reg       <= t.load_dst_reg;
    src_reg_a          <= t.src_reg_a;
    src_reg_b          <= t.src_reg_b;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  function automatic fetch_txn_t blank_txn();
    fetch_txn_t t;
    t = '{cmd: 1'b0,
          stage_icodes: {pfs_pkg::IC_NOP, pfs_pkg::IC_NOP, pfs_pkg::IC_NOP,
                         pfs_pkg::IC_NOP},
          cond_flags: 2'b11, branch_fallthrough: '0, return_addr: '0,
          fetch_error: 1'b0, instr_byte: {pfs_pkg::IC_NOP, pfs_pkg::FN_NONE},
          reg_byte: '0, const_word: '0, load_dst_reg: '0,
          src_reg_a: pfs_pkg::NO_REG, src_reg_b: pfs_pkg::NO_REG};
    return t;
  endfunction

  // Bias stage icodes toward the ones that drive selection and hazards.
  function automatic logic [3:0] pick_stage_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)      return pfs_pkg::IC_JXX;
    else if (r < 20) return pfs_pkg::IC_RET;
    else if (r < 30) return pfs_pkg::IC_MRMOVQ;
    else if (r < 40) return pfs_pkg::IC_POPQ;
    else if (r < 92) return 4'($urandom_range(0, 11));
    else             return 4'($urandom_range(12, 15));
  endfunction

  // Mostly full-range addresses, with some near zero and near the top so that
  // the increment wraps.
  function automatic logic [63:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)      return {60'hFFF_FFFF_FFFF_FFFF, 4'($urandom)};
    else if (r == 1) return {60'h0, 4'($urandom)};
    else             return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] pick_stage_codes();
    return {pick_stage_code(), pick_stage_code(), pick_stage_code(), pick_stage_code()};
  endfunction

  function automatic fetch_txn_t make_select();
    fetch_txn_t t;
    t = blank_txn();
    t.stage_icodes       = pick_stage_codes();
    t.cond_flags         = 2'($urandom);
    t.branch_fallthrough = pick_addr();
    t.return_addr        = pick_addr();
    return t;
  endfunction

  function automatic fetch_txn_t make_fetch();
    fetch_txn_t t;
    t = make_select();
    t.cmd          = 1'b1;
    t.fetch_error  = ($urandom_range(0, 19) == 0);
    t.instr_byte   = {($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                  : 4'($urandom_range(0, 11)),
                      4'($urandom)};
    t.reg_byte     = 8'($urandom);
    t.const_word   = pick_addr();
    t.load_dst_reg = 4'($urandom);
    // Make load-use hits common: tie each source to the load target one time in four.
    t.src_reg_a    = ($urandom_range(0, 3) == 0) ? t.load_dst_reg : 4'($urandom);
    t.src_reg_b    = ($urandom_range(0, 3) == 0) ? t.load_dst_reg : 4'($urandom);
    return t;
  endfunction

  function automatic fetch_txn_t make_noise();
    fetch_txn_t t;
    t.cmd                = 1'($urandom);
    t.stage_icodes       = 16'($urandom);
    t.cond_flags         = 2'($urandom);
    t.branch_fallthrough = {$urandom, $urandom};
    t.return_addr        = {$urandom, $urandom};
    t.fetch_error        = 1'($urandom);
    t.instr_byte         = 8'($urandom);
    t.reg_byte           = 8'($urandom);
    t.const_word         = {$urandom, $urandom};
    t.load_dst_reg       = 4'($urandom);
    t.src_reg_a          = 4'($urandom);
    t.src_reg_b          = 4'($urandom);
    return t;
  endfunction

  task automatic run_directed();
    fetch_txn_t t;
    // Fetch a halt before any select: uses the reset address.
    t = blank_txn();
    t.cmd        = 1'b1;
    t.instr_byte = {pfs_pkg::IC_HALT, pfs_pkg::FN_NONE};
    send(t);
    // Select with nothing in flight: take the prediction.
    send(blank_txn());
    // Mispredicted jump in M beats ret in W: take the fall-through address.
    t = blank_txn();
    t.stage_icodes       = {pfs_pkg::IC_NOP, pfs_pkg::IC_NOP, pfs_pkg::IC_JXX,
                            pfs_pkg::IC_RET};
    t.cond_flags         = 2'b01;
    t.branch_fallthrough = '1;
    t.return_addr        = 64'h0123_4567_89AB_CDEF;
    send(t);
    // Ten-byte instruction at the top address: wrap val_p and the prediction.
    t = blank_txn();
    t.cmd        = 1'b1;
    t.instr_byte = {pfs_pkg::IC_IRMOVQ, pfs_pkg::FN_NONE};
    t.reg_byte   = 8'hF3;
    t.const_word = '1;
    send(t);
    // Taken jump in M, ret in W: take the return address.
    t = blank_txn();
    t.stage_icodes       = {pfs_pkg::IC_NOP, pfs_pkg::IC_NOP, pfs_pkg::IC_JXX,
                            pfs_pkg::IC_RET};
    t.cond_flags         = 2'b10;
    t.branch_fallthrough = '1;
    t.return_addr        = 64'h0123_4567_89AB_CDEF;
    send(t);
    // Walk every icode; pair icodes 2 to 9 with one hazard or branch scenario each.
    for (int k = 0; k < 16; k++) begin
      t = blank_txn();
      t.cmd          = 1'b1;
      t.instr_byte   = {4'(k), ~4'(k)};
      t.reg_byte     = {4'(k), ~4'(k)};
      t.const_word   = {$urandom, $urandom};
      t.load_dst_reg = 4'(k);
      unique case (k)
        2: begin
          t.stage_icodes[11:8] = pfs_pkg::IC_MRMOVQ;
          t.src_reg_a          = 4'(k);
        end
        3: begin
          t.stage_icodes[11:8] = pfs_pkg::IC_POPQ;
          t.src_reg_b          = 4'(k);
        end
        4: t.stage_icodes[15:12] = pfs_pkg::IC_RET;
        5: t.stage_icodes[11:8]  = pfs_pkg::IC_RET;
        6: t.stage_icodes[7:4]   = pfs_pkg::IC_RET;
        7: begin
          t.stage_icodes[11:8] = pfs_pkg::IC_JXX;
          t.cond_flags         = 2'b10;
        end
        8: begin
          // Load-use and ret together: stall without the ret bubble.
          t.stage_icodes = {pfs_pkg::IC_RET, pfs_pkg::IC_MRMOVQ, pfs_pkg::IC_NOP,
                            pfs_pkg::IC_NOP};
          t.src_reg_a    = 4'(k);
        end
        9: t.stage_icodes[11:8] = pfs_pkg::IC_JXX;
        default: ;
      endcase
      send(t);
    end
    // Failed fetch of an all-ones byte: forced nop, address error.
    t = blank_txn();
    t.cmd         = 1'b1;
    t.fetch_error = 1'b1;
    t.instr_byte  = 8'hFF;
    t.reg_byte    = 8'hFF;
    t.const_word  = '1;
    send(t);
    send(blank_txn());
  endtask

  // Mostly well-formed select/fetch pairs, the rest fully random transactions.
  task automatic run_random(input int src_pct, input int snk_pct, input int n_items);
    int sent;
    sent         = 0;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        send(make_select());
        send(make_fetch());
        sent += 2;
      end else begin
        send(make_noise());
        sent++;
      end
    end
  endtask

  initial begin
    // Drive every input to a known value and hold reset.
    rst                <= 1'b1;
    in_valid           <= 1'b0;
    cmd                <= 1'b0;
    stage_icodes       <= '0;
    cond_flags         <= '0;
    branch_fallthrough <= '0;
    return_addr        <= '0;
    fetch_error        <= 1'b0;
    instr_byte         <= '0;
    reg_byte           <= '0;
    const_word         <= '0;
    load_dst_reg       <= '0;
    src_reg_a          <= '0;
    src_reg_b          <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 12;
    snk_idle_pct = 66;
    run_directed();
    run_random(12, 66, PHASE_ITEMS);
    run_random(66, 12, PHASE_ITEMS);
    run_random(0, 0, PHASE_ITEMS);
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then keep the clock running to catch
    // any stray result transaction.
    while (outstanding != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d select and %0d fetch transactions: every icode, fetch errors,",
             select_count, fetch_count);
    $display("load-use, ret and mispredict hazards, address wrap, three idling profiles.");
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
